// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/mec_pkg.sv =====
// Shared constants, types and saturating arithmetic for the escape count core.
package mec_pkg;

    localparam int ITER_WIDTH = 16;
    localparam int FRAC_BITS  = 59;
    localparam int DATA_W     = 64;
    localparam int CFG_W      = 16;
    localparam int COUNT_W    = 16;

    localparam logic signed [DATA_W-1:0] Q_ONE       = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] Q_QUARTER   = 64'sd1 <<< (FRAC_BITS - 2);
    localparam logic signed [DATA_W-1:0] Q_SIXTEENTH = 64'sd1 <<< (FRAC_BITS - 4);
    localparam logic signed [DATA_W-1:0] Q_TWO       = 64'sd1 <<< (FRAC_BITS + 1);
    localparam logic signed [DATA_W-1:0] Q_NEG_TWO   = -Q_TWO;
    localparam logic signed [DATA_W-1:0] Q_FOUR      = 64'sd1 <<< (FRAC_BITS + 2);
    localparam logic signed [DATA_W-1:0] Q_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN       = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RG_Y2,
        ST_RG_XQ,
        ST_RG_CARD,
        ST_RG_BULB,
        ST_IT_CHECK,
        ST_IT_R2,
        ST_IT_I2,
        ST_IT_RI,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] p;
    } t_mul_rsp;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

// ===== design/mec_mul.sv =====
// Shared Q4.59 multiplier built from four 32x32 partial products, floor rounding and saturation.
module mec_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mec_pkg::t_mul_req i_req,
    output mec_pkg::t_mul_rsp o_rsp
);
    import mec_pkg::*;

    localparam int HALF_W = DATA_W / 2;
    localparam int PROD_W = 2 * DATA_W;
    localparam logic [2:0] STEP_LAST = 3'd5;

    logic                     r_active;
    logic [2:0]               r_step;
    logic                     r_done;
    logic [DATA_W-1:0]        r_ua;
    logic [DATA_W-1:0]        r_ub;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_pp;
    logic [PROD_W-1:0]        r_acc;
    logic signed [DATA_W-1:0] r_p;

    logic [HALF_W-1:0]        a_part;
    logic [HALF_W-1:0]        b_part;
    logic [1:0]               prev;
    logic [6:0]               pp_shift;
    logic [PROD_W-1:0]        pp_ext;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-FRAC_BITS-1:0] scaled;
    logic signed [DATA_W-1:0] sat_p;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;

    always_comb begin
        a_part = r_step[1] ? r_ua[DATA_W-1:HALF_W] : r_ua[HALF_W-1:0];
        b_part = r_step[0] ? r_ub[DATA_W-1:HALF_W] : r_ub[HALF_W-1:0];
        prev   = r_step[1:0] - 2'd1;
        case (prev)
            2'd0:    pp_shift = 7'd0;
            2'd3:    pp_shift = 7'(DATA_W);
            default: pp_shift = 7'(HALF_W);
        endcase
        pp_ext = {{DATA_W{1'b0}}, r_pp} << pp_shift;
        prod   = r_neg ? (~r_acc + PROD_W'(1)) : r_acc;
        scaled = prod[PROD_W-1:FRAC_BITS];
        if (scaled[PROD_W-FRAC_BITS-1:DATA_W-1] == '0 ||
            scaled[PROD_W-FRAC_BITS-1:DATA_W-1] == '1) begin
            sat_p = scaled[DATA_W-1:0];
        end else begin
            sat_p = scaled[PROD_W-FRAC_BITS-1] ? Q_MIN : Q_MAX;
        end
        mag_a = i_req.a[DATA_W-1] ? (~i_req.a + DATA_W'(1)) : i_req.a;
        mag_b = i_req.b[DATA_W-1] ? (~i_req.b + DATA_W'(1)) : i_req.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_active && (r_step == STEP_LAST);
            if (i_req.start) begin
                r_active <= 1'b1;
                r_step   <= '0;
            end else if (r_active) begin
                r_step <= r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ua  <= mag_a;
            r_ub  <= mag_b;
            r_neg <= i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
            r_acc <= '0;
        end else if (r_active) begin
            r_pp <= DATA_W'(a_part) * DATA_W'(b_part);
            if (r_step != 3'd0 && r_step != STEP_LAST) begin
                r_acc <= r_acc + pp_ext;
            end
            if (r_step == STEP_LAST) begin
                r_p <= sat_p;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

// ===== design/mec_seq.sv =====
// Sequencer and orbit registers: region test unless far, then iteration on the shared multiplier.
module mec_seq (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [mec_pkg::ITER_WIDTH-1:0]         i_limit,
    input  logic signed [mec_pkg::DATA_W-1:0]      i_real_part,
    input  logic signed [mec_pkg::DATA_W-1:0]      i_imag_part,
    output logic                                   o_busy,
    output logic                                   o_done,
    output logic [mec_pkg::ITER_WIDTH-1:0]         o_count,
    output logic                                   o_inside,
    output mec_pkg::t_mul_req                      o_mul_req,
    input  mec_pkg::t_mul_rsp                      i_mul_rsp
);
    import mec_pkg::*;

    t_state r_state, n_state;
    logic   r_wait, n_wait;

    logic signed [DATA_W-1:0] r_x, n_x;
    logic signed [DATA_W-1:0] r_y, n_y;
    logic signed [DATA_W-1:0] r_y2, n_y2;
    logic signed [DATA_W-1:0] r_q, n_q;
    logic signed [DATA_W-1:0] r_re, n_re;
    logic signed [DATA_W-1:0] r_im, n_im;
    logic signed [DATA_W-1:0] r_r2, n_r2;
    logic signed [DATA_W-1:0] r_i2, n_i2;
    logic signed [DATA_W-1:0] r_ri, n_ri;
    logic signed [DATA_W-1:0] r_mod, n_mod;
    logic [ITER_WIDTH-1:0]    r_count, n_count;
    logic                     r_inside, n_inside;

    logic signed [DATA_W-1:0] xq;
    logic signed [DATA_W-1:0] xp1;
    logic signed [DATA_W-1:0] y2q;
    logic                     far;
    logic                     in_cardioid;
    logic                     in_bulb;
    logic                     keep_going;
    logic                     mul_state;

    always_comb begin
        xq          = r_x - Q_QUARTER;
        xp1         = r_x + Q_ONE;
        y2q         = r_y2 >>> 2;
        far         = (i_real_part > Q_TWO) || (i_real_part < Q_NEG_TWO) ||
                      (i_imag_part > Q_TWO) || (i_imag_part < Q_NEG_TWO);
        in_cardioid = i_mul_rsp.p <= y2q;
        in_bulb     = sat_add(i_mul_rsp.p, r_y2) <= Q_SIXTEENTH;
        keep_going  = (r_count < i_limit) && (r_mod < Q_FOUR);
        mul_state   = (r_state == ST_RG_Y2) || (r_state == ST_RG_XQ) ||
                      (r_state == ST_RG_CARD) || (r_state == ST_RG_BULB) ||
                      (r_state == ST_IT_R2) || (r_state == ST_IT_I2) ||
                      (r_state == ST_IT_RI);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = far ? ST_IT_CHECK : ST_RG_Y2;
                end
            end
            ST_RG_Y2: begin
                if (i_mul_rsp.done) begin
                    n_state = ST_RG_XQ;
                end
            end
            ST_RG_XQ: begin
                if (i_mul_rsp.done) begin
                    n_state = ST_RG_CARD;
                end
            end
            ST_RG_CARD: begin
                if (i_mul_rsp.done) begin
                    n_state = in_cardioid ? ST_DONE : ST_RG_BULB;
                end
            end
            ST_RG_BULB: begin
                if (i_mul_rsp.done) begin
                    n_state = in_bulb ? ST_DONE : ST_IT_CHECK;
                end
            end
            ST_IT_CHECK: begin
                n_state = keep_going ? ST_IT_R2 : ST_DONE;
            end
            ST_IT_R2: begin
                if (i_mul_rsp.done) begin
                    n_state = ST_IT_I2;
                end
            end
            ST_IT_I2: begin
                if (i_mul_rsp.done) begin
                    n_state = ST_IT_RI;
                end
            end
            ST_IT_RI: begin
                if (i_mul_rsp.done) begin
                    n_state = ST_IT_CHECK;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_wait   = r_wait;
        n_x      = r_x;
        n_y      = r_y;
        n_y2     = r_y2;
        n_q      = r_q;
        n_re     = r_re;
        n_im     = r_im;
        n_r2     = r_r2;
        n_i2     = r_i2;
        n_ri     = r_ri;
        n_mod    = r_mod;
        n_count  = r_count;
        n_inside = r_inside;
        o_mul_req.start = mul_state && !r_wait;
        o_mul_req.a     = '0;
        o_mul_req.b     = '0;
        if (mul_state) begin
            if (i_mul_rsp.done) begin
                n_wait = 1'b0;
            end else if (!r_wait) begin
                n_wait = 1'b1;
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_x      = i_real_part;
                    n_y      = i_imag_part;
                    n_r2     = '0;
                    n_i2     = '0;
                    n_ri     = '0;
                    n_mod    = '0;
                    n_count  = '0;
                    n_inside = 1'b0;
                    n_wait   = 1'b0;
                end
            end
            ST_RG_Y2: begin
                o_mul_req.a = r_y;
                o_mul_req.b = r_y;
                if (i_mul_rsp.done) begin
                    n_y2 = i_mul_rsp.p;
                end
            end
            ST_RG_XQ: begin
                o_mul_req.a = xq;
                o_mul_req.b = xq;
                if (i_mul_rsp.done) begin
                    n_q = sat_add(i_mul_rsp.p, r_y2);
                end
            end
            ST_RG_CARD: begin
                o_mul_req.a = r_q;
                o_mul_req.b = sat_add(r_q, xq);
                if (i_mul_rsp.done && in_cardioid) begin
                    n_inside = 1'b1;
                    n_count  = i_limit;
                end
            end
            ST_RG_BULB: begin
                o_mul_req.a = xp1;
                o_mul_req.b = xp1;
                if (i_mul_rsp.done && in_bulb) begin
                    n_inside = 1'b1;
                    n_count  = i_limit;
                end
            end
            ST_IT_CHECK: begin
                if (keep_going) begin
                    n_count = r_count + ITER_WIDTH'(1);
                    n_im    = sat_add(r_y, r_ri + r_ri);
                    n_re    = sat_add(r_x, r_r2 - r_i2);
                end
            end
            ST_IT_R2: begin
                o_mul_req.a = r_re;
                o_mul_req.b = r_re;
                if (i_mul_rsp.done) begin
                    n_r2 = i_mul_rsp.p;
                end
            end
            ST_IT_I2: begin
                o_mul_req.a = r_im;
                o_mul_req.b = r_im;
                if (i_mul_rsp.done) begin
                    n_i2 = i_mul_rsp.p;
                end
            end
            ST_IT_RI: begin
                o_mul_req.a = r_re;
                o_mul_req.b = r_im;
                if (i_mul_rsp.done) begin
                    n_ri  = i_mul_rsp.p;
                    n_mod = sat_add(r_r2, r_i2);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_y2     <= n_y2;
        r_q      <= n_q;
        r_re     <= n_re;
        r_im     <= n_im;
        r_r2     <= n_r2;
        r_i2     <= n_i2;
        r_ri     <= n_ri;
        r_mod    <= n_mod;
        r_count  <= n_count;
        r_inside <= n_inside;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_count  = r_count;
    assign o_inside = r_inside;

endmodule

// ===== design/mandelbrot_escape_count_core.sv =====
// Mandelbrot escape count core: limit register, sequencer and shared multiplier.
// One point at a time; busy stays high from the accepted item until its done strobe.
// Each multiplication runs as four partial products on the single shared 32x32 multiplier.
// Synchronous active-low reset returns to idle and sets the limit to 256.
module mandelbrot_escape_count_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [mec_pkg::DATA_W-1:0] i_real_part,
    input  logic signed [mec_pkg::DATA_W-1:0] i_imag_part,
    input  logic                              i_cfg_we,
    input  logic [mec_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                              o_done,
    output logic [mec_pkg::COUNT_W-1:0]       o_iteration_count,
    output logic                              o_shortcut_inside
);
    import mec_pkg::*;

    logic [ITER_WIDTH-1:0] r_limit;
    logic [ITER_WIDTH-1:0] count;
    logic                  accept;
    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ITER_WIDTH'(256);
        end else if (i_cfg_we) begin
            r_limit <= ITER_WIDTH'(i_cfg_wdata);
        end
    end

    mec_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_limit     (r_limit),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_count     (count),
        .o_inside    (o_shortcut_inside),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp)
    );

    mec_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_iteration_count = COUNT_W'(count);

endmodule

// ===== design/mec_checker.sv =====
// Port-level checker for the escape count core, bound to the top level.
`include "assert_macros.svh"

module mec_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_SAME(a_done_while_busy, i_clk, i_rst_n, o_done, busy)
    `ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, o_done, !busy && !o_done)
    `ASSERT_NEXT(a_idle_no_done, i_clk, i_rst_n, !busy, !o_done)

endmodule

bind mandelbrot_escape_count_core mec_checker u_mec_checker (.*);
